// ----- hw/rtl/rfcm_pkg.sv -----
// Shared types, constants and functions for the CRC-8 Manchester frame encoder.
// Used by every module under hw/rtl; depends on nothing.
package rfcm_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;
    localparam int unsigned CFG_INDEX_W     = 2;
    localparam int unsigned CFG_DATA_W      = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_PREAMBLE_LEN = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_WORD    = 2'd1;

    localparam logic [5:0]  PREAMBLE_LEN_RST = 6'd2;
    localparam logic [15:0] SYNC_WORD_RST    = 16'hA55A;
    localparam logic [5:0]  MAX_PREAMBLE     = 6'd32;
    localparam logic [7:0]  CRC_POLY         = 8'h07;
    localparam logic [7:0]  PREAMBLE_BYTE    = 8'h00;

    localparam logic [1:0] SEG_PREAMBLE = 2'd0;
    localparam logic [1:0] SEG_SYNC     = 2'd1;
    localparam logic [1:0] SEG_PAYLOAD  = 2'd2;
    localparam logic [1:0] SEG_CRC      = 2'd3;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       start;
        logic [7:0] crc;
    } cmd_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PRE,
        PH_SYNC_HI,
        PH_SYNC_LO,
        PH_DATA,
        PH_CRC
    } phase_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] b);
        logic [7:0] c;
        c = crc_in ^ b;
        for (int j = 0; j < 8; j++) begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [15:0] manchester(input logic [7:0] b);
        logic [15:0] w;
        w = '0;
        for (int i = 0; i < 8; i++) begin
            w[2*i+1 -: 2] = b[i] ? 2'b01 : 2'b10;
        end
        return w;
    endfunction

endpackage

// ----- hw/rtl/rfcm_front.sv -----
// Front end: accepts payload items, tracks frame start and the running CRC-8.
// Depends on rfcm_pkg; feeds rfcm_cmd_queue.
module rfcm_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  logic [7:0]    payload_byte,
    input  logic          last_of_payload,
    input  logic          q_full,
    output logic          q_push,
    output rfcm_pkg::cmd_t q_cmd
);
    import rfcm_pkg::*;

    logic       in_frame_reg, in_frame_next;
    logic [7:0] crc_reg, crc_next;
    logic [7:0] crc_upd;
    logic       start;

    assign full   = q_full;
    assign q_push = push && !q_full;
    assign start  = !in_frame_reg;

    always_comb
    begin
        crc_upd       = crc8_byte(start ? 8'h00 : crc_reg, payload_byte);
        in_frame_next = in_frame_reg;
        crc_next      = crc_reg;
        if (q_push)
        begin
            in_frame_next = !last_of_payload;
            crc_next      = last_of_payload ? 8'h00 : crc_upd;
        end
        q_cmd.data  = payload_byte;
        q_cmd.last  = last_of_payload;
        q_cmd.start = start;
        q_cmd.crc   = crc_upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            crc_reg      <= 8'h00;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            crc_reg      <= crc_next;
        end
    end

endmodule

// ----- hw/rtl/rfcm_cmd_queue.sv -----
// Short register queue of classified items between front and back end.
// Depends on rfcm_pkg for the item type.
module rfcm_cmd_queue #(
    parameter int unsigned DEPTH = rfcm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  rfcm_pkg::cmd_t wr_cmd,
    output logic           q_full,
    input  logic           rd_en,
    output logic           rd_valid,
    output rfcm_pkg::cmd_t rd_cmd
);
    import rfcm_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    cmd_t            mem_reg [DEPTH];
    logic [PW-1:0]   wptr_reg, wptr_next;
    logic [PW-1:0]   rptr_reg, rptr_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            do_wr, do_rd;

    assign q_full   = (cnt_reg == CW'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_cmd   = mem_reg[rptr_reg];
    assign do_wr    = wr_en && !q_full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_wr)
        begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        case ({do_wr, do_rd})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ----- hw/rtl/rfcm_back.sv -----
// Back end: expands queued items into preamble, sync, payload and CRC words,
// Manchester codes them and holds the result in an output register. Uses rfcm_pkg.
module rfcm_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  rfcm_pkg::cmd_t cmd,
    output logic           cmd_pop,
    input  logic [5:0]     preamble_len,
    input  logic [15:0]    sync_word,
    output logic           empty,
    input  logic           pop,
    output logic [15:0]    encoded_word,
    output logic [1:0]     segment,
    output logic           end_of_frame
);
    import rfcm_pkg::*;

    phase_t      state_reg, state_next;
    phase_t      cur;
    logic [5:0]  cnt_reg, cnt_next;
    logic [5:0]  npre;
    logic        emit;
    logic [7:0]  sel_byte;
    logic [1:0]  sel_seg;
    logic        sel_eof;
    logic        ovalid_reg, ovalid_next;
    logic [15:0] oword_reg;
    logic [1:0]  oseg_reg;
    logic        oeof_reg;

    assign npre         = (preamble_len > MAX_PREAMBLE) ? MAX_PREAMBLE : preamble_len;
    assign emit         = cmd_valid && (!ovalid_reg || pop);
    assign empty        = !ovalid_reg;
    assign encoded_word = oword_reg;
    assign segment      = oseg_reg;
    assign end_of_frame = oeof_reg;

    always_comb
    begin
        if (state_reg != PH_IDLE)
        begin
            cur = state_reg;
        end
        else if (cmd.start)
        begin
            cur = (npre != 6'd0) ? PH_PRE : PH_SYNC_HI;
        end
        else
        begin
            cur = PH_DATA;
        end

        sel_byte   = cmd.data;
        sel_seg    = SEG_PAYLOAD;
        sel_eof    = 1'b0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd_pop    = 1'b0;

        case (cur)
            PH_PRE:
            begin
                sel_byte = PREAMBLE_BYTE;
                sel_seg  = SEG_PREAMBLE;
                if (emit)
                begin
                    if (cnt_reg + 6'd1 == npre)
                    begin
                        state_next = PH_SYNC_HI;
                        cnt_next   = 6'd0;
                    end
                    else
                    begin
                        state_next = PH_PRE;
                        cnt_next   = cnt_reg + 6'd1;
                    end
                end
            end
            PH_SYNC_HI:
            begin
                sel_byte = sync_word[15:8];
                sel_seg  = SEG_SYNC;
                if (emit)
                begin
                    state_next = PH_SYNC_LO;
                end
            end
            PH_SYNC_LO:
            begin
                sel_byte = sync_word[7:0];
                sel_seg  = SEG_SYNC;
                if (emit)
                begin
                    state_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (emit)
                begin
                    if (cmd.last)
                    begin
                        state_next = PH_CRC;
                    end
                    else
                    begin
                        state_next = PH_IDLE;
                        cmd_pop    = 1'b1;
                    end
                end
            end
            PH_CRC:
            begin
                sel_byte = cmd.crc;
                sel_seg  = SEG_CRC;
                sel_eof  = 1'b1;
                if (emit)
                begin
                    state_next = PH_IDLE;
                    cmd_pop    = 1'b1;
                end
            end
            default:
            begin
                state_next = PH_IDLE;
            end
        endcase

        ovalid_next = ovalid_reg;
        if (emit)
        begin
            ovalid_next = 1'b1;
        end
        else if (pop)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            oword_reg <= manchester(sel_byte);
            oseg_reg  <= sel_seg;
            oeof_reg  <= sel_eof;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= PH_IDLE;
            cnt_reg    <= 6'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

// ----- hw/rtl/rf_frame_crc8_manchester_encoder_top.sv -----
// Top level of the CRC-8 Manchester frame encoder: config registers, front end,
// item queue and back end. Depends on rfcm_pkg, rfcm_front, rfcm_cmd_queue, rfcm_back.
// An item's first word is held in the item queue and then the output register.
// One coded word per cycle while the output is not held; an item gives one word, plus
// a CRC word on the last byte and min(preamble_len, 32) + 2 on a frame's first byte.
// Reset clears frame state, queue and output register; config returns to 2 and 0xA55A.
module rf_frame_crc8_manchester_encoder_top #(
    parameter int unsigned QUEUE_DEPTH = rfcm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [7:0]                           payload_byte,
    input  logic                                 last_of_payload,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [15:0]                          encoded_word,
    output logic [1:0]                           segment,
    output logic                                 end_of_frame,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rfcm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rfcm_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import rfcm_pkg::*;

    logic [5:0]  preamble_len_reg;
    logic [15:0] sync_word_reg;
    logic        q_full, q_push, q_valid, q_pop;
    cmd_t        q_wr_cmd, q_rd_cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            preamble_len_reg <= PREAMBLE_LEN_RST;
            sync_word_reg    <= SYNC_WORD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PREAMBLE_LEN: preamble_len_reg <= cfg_data[5:0];
                REG_SYNC_WORD:    sync_word_reg    <= cfg_data[15:0];
                default:          ;
            endcase
        end
    end

    rfcm_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .payload_byte    (payload_byte),
        .last_of_payload (last_of_payload),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_cmd           (q_wr_cmd)
    );

    rfcm_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_cmd   (q_wr_cmd),
        .q_full   (q_full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_cmd   (q_rd_cmd)
    );

    rfcm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (q_valid),
        .cmd          (q_rd_cmd),
        .cmd_pop      (q_pop),
        .preamble_len (preamble_len_reg),
        .sync_word    (sync_word_reg),
        .empty        (empty),
        .pop          (pop),
        .encoded_word (encoded_word),
        .segment      (segment),
        .end_of_frame (end_of_frame)
    );

endmodule
